FILE: src/tabc_pkg.sv
// Shared types and constants for the table-based arithmetic-to-Boolean mask converter.
// Used by tabc_core, table_arith_to_bool_mask_convert and the testbench. No dependencies.
`timescale 1ns / 1ps

package tabc_pkg;

    // Width of every share and of the table mask register.
    localparam int FIELD_BITS = 16;

    // Default digit geometry.
    localparam int DIGIT_BITS_DEF  = 4;
    localparam int DIGIT_COUNT_DEF = 4;

    // Configuration register indexes.
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_TABLE_MASK = 1'b0;
    localparam cfg_index_t CFG_CARRY_MASK = 1'b1;

    // Configuration handed from the register file to the datapath.
    typedef struct packed {
        logic [FIELD_BITS-1:0] table_mask;
        logic                  carry_mask;
    } tabc_cfg_t;

endpackage

FILE: src/tabc_digit.sv
// One digit cell of the conversion: adds the mask digit, forms the table entry on the fly
// and passes the masked carry on. Depends on nothing outside this file.
`timescale 1ns / 1ps

module tabc_digit
#(
    parameter int DIGIT_BITS = 4,
    parameter int TOTAL_BITS = 16,
    parameter int LIVE_BITS  = 16
)
(
    input  logic [TOTAL_BITS-1:0] acc_in,
    input  logic [DIGIT_BITS-1:0] r_dig,
    input  logic [DIGIT_BITS-1:0] t_dig,
    input  logic                  beta_in,
    input  logic                  carry_mask,
    output logic [TOTAL_BITS-1:0] acc_out,
    output logic [DIGIT_BITS-1:0] b_dig,
    output logic                  beta_out
);

    localparam int ENTRY_BITS = DIGIT_BITS + 1;
    localparam logic [TOTAL_BITS-1:0] LIVE_MASK = {TOTAL_BITS{1'b1}} >> (TOTAL_BITS - LIVE_BITS);

    logic [TOTAL_BITS-1:0] acc_sum;
    logic [TOTAL_BITS-1:0] acc_live;
    logic                  carry_in;
    logic [ENTRY_BITS-1:0] entry_sum;
    logic [ENTRY_BITS-1:0] entry;

    // Add the mask digit into the remaining accumulator, keeping only the live digits.
    assign acc_sum  = acc_in + TOTAL_BITS'(r_dig);
    assign acc_live = acc_sum & LIVE_MASK;
    assign acc_out  = acc_live >> DIGIT_BITS;

    // Table entry: unmask the carry, add the table mask digit, then remask sum and carry.
    assign carry_in  = beta_in ^ carry_mask;
    assign entry_sum = {1'b0, acc_live[DIGIT_BITS-1:0]} + {1'b0, t_dig}
                     + ENTRY_BITS'(carry_in);
    assign entry     = entry_sum ^ {carry_mask, t_dig};

    // Sum digit moves from the table mask over to the Boolean mask.
    assign b_dig    = entry[DIGIT_BITS-1:0] ^ r_dig;
    assign beta_out = entry[DIGIT_BITS];

endmodule

FILE: src/tabc_core.sv
// Combinational conversion datapath: subtracts the table mask and ripples through the
// digit cells. Depends on tabc_pkg and tabc_digit.
`timescale 1ns / 1ps

module tabc_core
    import tabc_pkg::*;
#(
    parameter int DIGIT_BITS  = DIGIT_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic [FIELD_BITS-1:0] a_share,
    input  logic [FIELD_BITS-1:0] r_mask,
    input  tabc_cfg_t             cfg,
    output logic [FIELD_BITS-1:0] b_share
);

    localparam int TOTAL_BITS = DIGIT_BITS * DIGIT_COUNT;

    logic [TOTAL_BITS-1:0] a_w;
    logic [TOTAL_BITS-1:0] r_w;
    logic [TOTAL_BITS-1:0] t_w;
    logic [TOTAL_BITS-1:0] res_w;
    logic [TOTAL_BITS-1:0] acc_chain  [DIGIT_COUNT+1];
    logic                  beta_chain [DIGIT_COUNT+1];

    // Bring shares and table mask to the working width.
    assign a_w = TOTAL_BITS'(a_share);
    assign r_w = TOTAL_BITS'(r_mask);
    assign t_w = TOTAL_BITS'(cfg.table_mask);

    // Remove the table mask before the digit ripple.
    assign acc_chain[0]  = a_w - t_w;
    assign beta_chain[0] = cfg.carry_mask;

    // Ripple of digit cells, least significant digit first.
    for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
        tabc_digit
        #(
            .DIGIT_BITS (DIGIT_BITS),
            .TOTAL_BITS (TOTAL_BITS),
            .LIVE_BITS  ((DIGIT_COUNT - i) * DIGIT_BITS)
        )
        u_digit
        (
            .acc_in     (acc_chain[i]),
            .r_dig      (r_w[i*DIGIT_BITS +: DIGIT_BITS]),
            .t_dig      (t_w[i*DIGIT_BITS +: DIGIT_BITS]),
            .beta_in    (beta_chain[i]),
            .carry_mask (cfg.carry_mask),
            .acc_out    (acc_chain[i+1]),
            .b_dig      (res_w[i*DIGIT_BITS +: DIGIT_BITS]),
            .beta_out   (beta_chain[i+1])
        );
    end

    // Strip the table mask from the digits, leaving the Boolean share under r_mask.
    assign b_share = FIELD_BITS'(res_w ^ t_w);

endmodule

FILE: src/table_arith_to_bool_mask_convert.sv
// Top level of the table-based arithmetic-to-Boolean mask converter: stream ports,
// configuration registers and the two pipeline registers. Depends on tabc_pkg, tabc_core.
`timescale 1ns / 1ps

// Converts an arithmetic share (a_share + r_mask) into a Boolean share (b_share ^ r_mask)
// with the same mask, without forming the clear value. One request is accepted per clock
// cycle unless the result side holds it off; the DIGIT_COUNT digit cells ripple while it
// sits in the input register, and its result then moves to the result register and is
// presented on the master side. The slave side keeps accepting while a result waits, as
// long as the input register is free. The table mask (index 0) and carry mask (index 1)
// reset to zero and should only be written while no request is in flight.

module table_arith_to_bool_mask_convert
    import tabc_pkg::*;
#(
    parameter int DIGIT_BITS  = DIGIT_BITS_DEF,
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  cfg_index_t              cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_data,

    // Input stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*FIELD_BITS-1:0] s_tdata,   // a_share [15:0], r_mask [31:16]

    // Result stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [FIELD_BITS-1:0]   m_tdata    // b_share [15:0]
);

    tabc_cfg_t             cfg_reg;
    tabc_cfg_t             cfg_next;

    logic                  in_valid_reg;
    logic [FIELD_BITS-1:0] a_share_reg;
    logic [FIELD_BITS-1:0] r_mask_reg;

    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] b_share_reg;
    logic [FIELD_BITS-1:0] b_share_next;

    logic                  out_free;
    logic                  in_accept;

    // Configuration register write decode.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TABLE_MASK: cfg_next.table_mask = cfg_data;
                CFG_CARRY_MASK: cfg_next.carry_mask = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline flow control: the result register frees up when empty or drained.
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_share_reg <= s_tdata[FIELD_BITS-1:0];
            r_mask_reg  <= s_tdata[2*FIELD_BITS-1:FIELD_BITS];
        end
    end

    // Conversion datapath.
    tabc_core
    #(
        .DIGIT_BITS  (DIGIT_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    )
    u_core
    (
        .a_share (a_share_reg),
        .r_mask  (r_mask_reg),
        .cfg     (cfg_reg),
        .b_share (b_share_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            b_share_reg <= b_share_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = b_share_reg;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for table_arith_to_bool_mask_convert: a directed table, then
// random phases under several mask settings, all checked against an in-bench predictor.
// Depends on tabc_pkg and the table_arith_to_bool_mask_convert RTL.
`timescale 1ns / 1ps

module tb;
    import tabc_pkg::*;

    localparam int DBITS        = DIGIT_BITS_DEF;
    localparam int DCOUNT       = DIGIT_COUNT_DEF;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 104;
    localparam int STALL_LIMIT  = 2000;

    typedef logic [FIELD_BITS-1:0] share_t;

    // Request word on the slave side, a_share in the low half.
    typedef struct packed {
        share_t r_mask;
        share_t a_share;
    } share_req_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        share_t     a_share;
        share_t     r_mask;
        cfg_index_t index;
        share_t     value;
        bit         typed;
        share_t     b_share;
    } plan_row_t;

    typedef struct {
        bit     typed;
        share_t b_share;
    } typed_b_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    share_t     cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    share_req_t s_req;
    logic       m_tvalid;
    logic       m_tready;
    share_t     m_tdata;

    // Mask settings as seen by the checker, updated on each accepted register write.
    share_t     mask_table;
    logic       mask_carry;

    share_t     expected_b_q[$];
    typed_b_t   typed_b_q[$];
    int         sent_count;
    int         result_count;
    int         fail_count;
    int         gap_odds;
    int         stall_odds;
    int         quiet_cycles;

    table_arith_to_bool_mask_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Digit-serial conversion: subtract the table mask, then per digit add the mask
    // digit, form the masked table entry and pass its masked carry upward.
    function automatic share_t convert_share(share_t a_share, share_t r_mask,
                                             share_t tmask, logic cmask);
        share_t           acc;
        share_t           rem;
        share_t           res;
        logic             carry_m;
        logic [DBITS-1:0] rdig;
        logic [DBITS-1:0] tdig;
        logic [DBITS:0]   entry;
        int               i;
        acc     = a_share - tmask;
        rem     = r_mask;
        res     = '0;
        carry_m = cmask;
        for (i = 0; i < DCOUNT; i++)
        begin
            rdig    = rem[DBITS-1:0];
            tdig    = tmask[i*DBITS +: DBITS];
            acc     = (acc + share_t'(rdig)) & (share_t'('1) >> (i * DBITS));
            entry   = {1'b0, acc[DBITS-1:0]} + {1'b0, tdig} + (DBITS+1)'(carry_m ^ cmask);
            entry   = entry ^ {cmask, tdig};
            res[i*DBITS +: DBITS] = entry[DBITS-1:0] ^ rdig;
            carry_m = entry[DBITS];
            acc     = acc >> DBITS;
            rem     = rem >> DBITS;
        end
        return res ^ tmask;
    endfunction

    function automatic plan_row_t item_row(share_t a_share, share_t r_mask,
                                           bit typed, share_t b_share);
        plan_row_t row;
        row = '{ROW_ITEM, a_share, r_mask, CFG_TABLE_MASK, '0, typed, b_share};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(cfg_index_t index, share_t value);
        plan_row_t row;
        row = '{ROW_CFG, '0, '0, index, value, 1'b0, '0};
        return row;
    endfunction

    // Field values lean toward the extremes now and then.
    function automatic share_t pick_share();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return share_t'($urandom);
        endcase
    endfunction

    // Register write over the configuration channel; called at a rising edge.
    // The channel is left idle afterward.
    task automatic write_reg(cfg_index_t index, share_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One request, with an optional idle burst ahead of it; valid stays high after.
    task automatic send_share(share_t a_share, share_t r_mask, bit typed, share_t b_share);
        typed_b_t tag;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
        tag.typed   = typed;
        tag.b_share = b_share;
        typed_b_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_req    <= '{r_mask: r_mask, a_share: a_share};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // Wait until every result is back so that the masks can change.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (result_count != sent_count)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Result side: ready drops in random bursts while stall_odds is nonzero.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 11);
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Checker: tracks the masks, predicts each accepted request and compares results.
    always @(posedge clk)
    begin : score
        typed_b_t tag;
        share_t   want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TABLE_MASK: mask_table = cfg_data;
                    CFG_CARRY_MASK: mask_carry = cfg_data[0];
                    default:        ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                tag = typed_b_q.pop_front();
                if (tag.typed)
                    expected_b_q.push_back(tag.b_share);
                else
                    expected_b_q.push_back(convert_share(s_req.a_share, s_req.r_mask,
                                                         mask_table, mask_carry));
            end
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (expected_b_q.size() == 0)
                begin
                    $error("unexpected result: b_share %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_b_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("b_share mismatch: expected %h, actual %h", want, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request, result or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Stimulus: directed table, random phases, then drain and verdict.
    initial
    begin
        plan_row_t plan[];
        share_t    tmask;
        int        p;
        int        n;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_req        <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_TABLE_MASK;
        cfg_data     <= '0;
        mask_table   = '0;
        mask_carry   = 1'b0;
        sent_count   = 0;
        result_count = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        gap_odds     = 4;
        stall_odds   = 4;

        // With any masks the result equals (a_share + r_mask) xor r_mask.
        plan = '{
            item_row(16'h0000, 16'h0000, 1'b1, 16'h0000),
            item_row(16'hFFFF, 16'h0000, 1'b1, 16'hFFFF),
            item_row(16'h0000, 16'hFFFF, 1'b1, 16'h0000),
            item_row(16'hFFFF, 16'hFFFF, 1'b1, 16'h0001),
            item_row(16'h0001, 16'hFFFF, 1'b1, 16'hFFFF),
            item_row(16'h8000, 16'h8000, 1'b1, 16'h8000),
            item_row(16'h1234, 16'h5678, 1'b0, '0),
            cfg_row(CFG_TABLE_MASK, 16'hFFFF),
            cfg_row(CFG_CARRY_MASK, 16'h0001),
            item_row(16'h0000, 16'h0000, 1'b1, 16'h0000),
            item_row(16'hFFFF, 16'hFFFF, 1'b1, 16'h0001),
            item_row(16'h000F, 16'h0001, 1'b0, '0),
            item_row(16'h0FFF, 16'h0001, 1'b0, '0),
            item_row(16'hFFFF, 16'h0001, 1'b1, 16'h0001),
            cfg_row(CFG_TABLE_MASK, 16'h0000),
            item_row(16'hFFFF, 16'h0001, 1'b0, '0),
            item_row(16'hA5A5, 16'h5A5A, 1'b0, '0),
            cfg_row(CFG_TABLE_MASK, 16'h8421),
            cfg_row(CFG_CARRY_MASK, 16'hFFFE),
            item_row(16'h7BDE, 16'h8421, 1'b0, '0),
            item_row(16'hFFFF, 16'hFFFF, 1'b1, 16'h0001),
            item_row(16'h0000, 16'hFFFF, 1'b1, 16'h0000)
        };

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].index, plan[i].value);
            end
            else
                send_share(plan[i].a_share, plan[i].r_mask, plan[i].typed, plan[i].b_share);
        end

        // Random phases; the first four pin the mask extremes, the last runs without idling.
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:       tmask = 16'h0000;
                1, 2:    tmask = 16'hFFFF;
                3:       tmask = 16'h0000;
                default: tmask = share_t'($urandom);
            endcase
            write_reg(CFG_TABLE_MASK, tmask);
            write_reg(CFG_CARRY_MASK,
                      {15'($urandom), (p < 4) ? p[0] : 1'($urandom)});
            if (p == PHASES - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    default: stall_odds = 8;
                endcase
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send_share(pick_share(), pick_share(), 1'b0, '0);
        end

        settle();
        repeat (8)
            @(posedge clk);
        if (expected_b_q.size() != 0)
        begin
            $error("%0d b_share results never arrived", expected_b_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: sim.f
src/tabc_pkg.sv
src/tabc_digit.sv
src/tabc_core.sv
src/table_arith_to_bool_mask_convert.sv
verif/tb.sv
